@@ rtl/gadc_pkg.sv @@
// ----------------------------------------------------------------------------
// gadc_pkg
// Shared types and constants of the grid average dominant colors block.
// ----------------------------------------------------------------------------
package gadc_pkg;

  // fixed field widths of the ports
  localparam int unsigned CFG_DIM_W = 13;
  localparam int unsigned CFG_CW_W  = 5;
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned COUNT_W   = 5;

  // register indexes of the configuration port
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLORS = 2'd2;

  // controller states
  typedef enum logic [3:0] {
    ST_RUN,
    ST_DIV,
    ST_DIVW,
    ST_FRAME,
    ST_CNT,
    ST_CHK,
    ST_SELI,
    ST_SEL,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_store;
    logic sums_clear;
    logic avg_zero;
    logic cnt_clear;
    logic cnt_step;
    logic sel_start;
    logic sel_step;
    logic emit_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic fire;
    logic row_end;
    logic frame_end;
    logic geo_busy;
    logic div_done;
    logic div_last;
    logic rh_zero;
    logic cnt_last;
    logic sel_last;
    logic want_zero;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/grid_average_dominant_colors.sv @@
// ----------------------------------------------------------------------------
// grid_average_dominant_colors
// Region average colours of a frame on a grid, reported by frequency.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle in raster order. At the last pixel of each
// region row the input stalls while one shared serial divider forms the
// GRID*3 averages one after another. At frame end the input stalls for the
// merge pass over the NREG = GRID*GRID regions and then for a selection scan
// per reported colour, plus any wait on out_tready. After every configuration
// write the input is held off while the region geometry is recomputed.
module grid_average_dominant_colors
  import gadc_pkg::*;
#(
  parameter int GRID         = 5,
  parameter int CHANNEL_BITS = 16,
  parameter int MAX_DIM      = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [CFG_DIM_W-1:0] cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // pix_red, pix_green, pix_blue
  input  logic [47:0]          in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // avg_red, avg_green, avg_blue, region_count, zero fill
  output logic [55:0]          out_tdata,
  output logic                 out_tlast
);

  cmd_t               cmd;
  sts_t               sts;
  logic [FIELD_W-1:0] avg_red, avg_green, avg_blue;
  logic [COUNT_W-1:0] region_count;

  gadc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  gadc_dp #(
    .GRID         (GRID),
    .CHANNEL_BITS (CHANNEL_BITS),
    .MAX_DIM      (MAX_DIM)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .pix_red      (in_tdata[15:0]),
    .pix_green    (in_tdata[31:16]),
    .pix_blue     (in_tdata[47:32]),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .avg_red      (avg_red),
    .avg_green    (avg_green),
    .avg_blue     (avg_blue),
    .region_count (region_count),
    .final_flag   (out_tlast)
  );

  // stream packing
  assign in_tready = cmd.accept;
  assign out_tdata = {3'b000, region_count, avg_blue, avg_green, avg_red};

endmodule

@@ rtl/gadc_div.sv @@
// ----------------------------------------------------------------------------
// gadc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gadc_div #(
  parameter int SUM_W  = 36,
  parameter int AREA_W = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [AREA_W-1:0] divisor,
  output logic              done,
  output logic [SUM_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  dvd_r;
  logic [AREA_W-1:0] rem_r;
  logic [AREA_W-1:0] rem_nxt;
  logic [AREA_W-1:0] dsr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [AREA_W:0]   trial;
  logic [AREA_W:0]   diff;
  logic              ge;

  // one trial subtraction
  always_comb begin
    trial   = {rem_r, dvd_r[SUM_W-1]};
    diff    = trial - {1'b0, dsr_r};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? diff[AREA_W-1:0] : trial[AREA_W-1:0];
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
        cnt_r  <= CNT_W'(SUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[SUM_W-2:0], ge};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

@@ rtl/gadc_dp.sv @@
// ----------------------------------------------------------------------------
// gadc_dp
// Datapath: geometry, raster position, region sums, averages, merge and rank.
// ----------------------------------------------------------------------------
module gadc_dp
  import gadc_pkg::*;
#(
  parameter int GRID         = 5,
  parameter int CHANNEL_BITS = 16,
  parameter int MAX_DIM      = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [CFG_DIM_W-1:0] cfg_wdata,
  input  logic                 in_tvalid,
  input  logic [FIELD_W-1:0]   pix_red,
  input  logic [FIELD_W-1:0]   pix_green,
  input  logic [FIELD_W-1:0]   pix_blue,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [FIELD_W-1:0]   avg_red,
  output logic [FIELD_W-1:0]   avg_green,
  output logic [FIELD_W-1:0]   avg_blue,
  output logic [COUNT_W-1:0]   region_count,
  output logic                 final_flag
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int POS_W  = $clog2(MAX_DIM);
  localparam int RW_W   = $clog2(MAX_DIM / GRID + 1);
  localparam int AREA_W = 2 * RW_W;
  localparam int SUM_W  = CHANNEL_BITS + AREA_W;
  localparam int RX_W   = $clog2(GRID);
  localparam int NREG   = GRID * GRID;
  localparam int AV_W   = $clog2(NREG);
  localparam int N_W    = $clog2(NREG + 1);
  localparam int CB     = CHANNEL_BITS;
  localparam int SHIFT  = 18;
  localparam int RECIP  = ((1 << SHIFT) + GRID - 1) / GRID;
  localparam int MUL_W  = DIM_W + SHIFT;
  localparam int CL_W   = CFG_DIM_W + 1;
  localparam int WANT_W = 8;

  // configuration registers
  logic [CFG_DIM_W-1:0] cfg_w_r;
  logic [CFG_DIM_W-1:0] cfg_h_r;
  logic [CFG_CW_W-1:0]  cfg_cw_r;
  logic [1:0]           geo_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= CFG_DIM_W'(640);
      cfg_h_r   <= CFG_DIM_W'(480);
      cfg_cw_r  <= CFG_CW_W'(5);
      geo_cnt_r <= 2'd3;
    end else begin
      if (cfg_we) begin
        geo_cnt_r <= 2'd3;
        case (cfg_addr)
          REG_WIDTH:  cfg_w_r  <= cfg_wdata;
          REG_HEIGHT: cfg_h_r  <= cfg_wdata;
          REG_COLORS: cfg_cw_r <= cfg_wdata[CFG_CW_W-1:0];
          default: ;
        endcase
      end else if (geo_cnt_r != 2'd0) begin
        geo_cnt_r <= geo_cnt_r - 2'd1;
      end
    end
  end

  // geometry pipeline: clamp, region size, bounds and area
  logic [CL_W-1:0]  w_cl, h_cl;
  logic [DIM_W-1:0] w_c_r, h_c_r;
  logic [MUL_W-1:0] w_prod, h_prod;
  logic [RW_W-1:0]  rw_r, rh_r;
  logic [DIM_W-1:0] bnd_c_r [GRID];
  logic [DIM_W-1:0] bnd_r_r [GRID];
  logic [AREA_W-1:0] area_r;

  always_comb begin
    if (cfg_w_r == '0) w_cl = CL_W'(1);
    else if ({1'b0, cfg_w_r} > CL_W'(MAX_DIM)) w_cl = CL_W'(MAX_DIM);
    else w_cl = {1'b0, cfg_w_r};
    if (cfg_h_r == '0) h_cl = CL_W'(1);
    else if ({1'b0, cfg_h_r} > CL_W'(MAX_DIM)) h_cl = CL_W'(MAX_DIM);
    else h_cl = {1'b0, cfg_h_r};
    w_prod = MUL_W'(w_c_r) * MUL_W'(RECIP);
    h_prod = MUL_W'(h_c_r) * MUL_W'(RECIP);
  end

  always_ff @(posedge clk) begin
    w_c_r  <= DIM_W'(w_cl);
    h_c_r  <= DIM_W'(h_cl);
    rw_r   <= RW_W'(w_prod >> SHIFT);
    rh_r   <= RW_W'(h_prod >> SHIFT);
    area_r <= AREA_W'(rw_r) * AREA_W'(rh_r);
    for (int k = 0; k < GRID; k++) begin
      bnd_c_r[k] <= DIM_W'(int'(rw_r) * (k + 1));
      bnd_r_r[k] <= DIM_W'(int'(rh_r) * (k + 1));
    end
  end

  // raster position and region lookup
  logic [POS_W-1:0] col_r, row_r;
  logic [RX_W-1:0]  rx, ry, ry_r;
  logic [DIM_W-1:0] col_d, row_d;
  logic             in_range, col_end, row_last, row_end, fire;

  always_comb begin
    col_d = DIM_W'(col_r);
    row_d = DIM_W'(row_r);
    rx = '0;
    ry = '0;
    for (int k = 0; k < GRID - 1; k++) begin
      if (col_d >= bnd_c_r[k]) rx = rx + RX_W'(1);
      if (row_d >= bnd_r_r[k]) ry = ry + RX_W'(1);
    end
    fire     = cmd.accept && in_tvalid;
    in_range = (col_d < bnd_c_r[GRID-1]) && (row_d < bnd_r_r[GRID-1]);
    col_end  = col_d >= (w_c_r - DIM_W'(1));
    row_last = row_d >= (h_c_r - DIM_W'(1));
    row_end  = col_end && (rh_r != '0) && (row_d < bnd_r_r[GRID-1]) &&
               ((row_d + DIM_W'(1)) == bnd_r_r[ry]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ry_r  <= '0;
    end else if (fire) begin
      if (row_end) ry_r <= ry;
      if (col_end) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + POS_W'(1);
      end else begin
        col_r <= col_r + POS_W'(1);
      end
    end
  end

  // region sums of the current region row
  logic [SUM_W-1:0] sums_r [GRID][3];
  logic [CB-1:0]    pix [3];

  always_comb begin
    pix[0] = pix_red[CB-1:0];
    pix[1] = pix_green[CB-1:0];
    pix[2] = pix_blue[CB-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.sums_clear || !rst_n) begin
      for (int x = 0; x < GRID; x++)
        for (int c = 0; c < 3; c++) sums_r[x][c] <= '0;
    end else if (fire && in_range) begin
      for (int c = 0; c < 3; c++) sums_r[rx][c] <= sums_r[rx][c] + SUM_W'(pix[c]);
    end
  end

  // shared divider
  logic [RX_W-1:0]  dx_r;
  logic [1:0]       dch_r;
  logic             div_done;
  logic [SUM_W-1:0] quo;
  logic [AV_W-1:0]  widx;

  gadc_div #(
    .SUM_W  (SUM_W),
    .AREA_W (AREA_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sums_r[dx_r][dch_r]),
    .divisor  (area_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign widx = AV_W'(int'(ry_r) * GRID + int'(dx_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r  <= '0;
      dch_r <= '0;
    end else if (cmd.div_store) begin
      if (dch_r == 2'd2) begin
        dch_r <= '0;
        dx_r  <= (dx_r == RX_W'(GRID - 1)) ? '0 : dx_r + RX_W'(1);
      end else begin
        dch_r <= dch_r + 2'd1;
      end
    end
  end

  // region averages, merge counts and ranking
  logic [CB-1:0]     avg_r [NREG][3];
  logic [N_W-1:0]    cnt_r [NREG];
  logic [NREG-1:0]   dup_r, done_r, match, lower;
  logic [N_W-1:0]    n_r, k_r;
  logic [AV_W-1:0]   scan_r;
  logic              best_v_r;
  logic [AV_W-1:0]   best_idx_r;
  logic [N_W-1:0]    best_cnt_r;
  logic [3*CB-1:0]   best_rgb_r, scan_rgb;
  logic              cand, better;
  logic [WANT_W-1:0] want;

  always_comb begin
    scan_rgb = {avg_r[scan_r][0], avg_r[scan_r][1], avg_r[scan_r][2]};
    for (int i = 0; i < NREG; i++) begin
      match[i] = {avg_r[i][0], avg_r[i][1], avg_r[i][2]} == scan_rgb;
      lower[i] = AV_W'(i) < scan_r;
    end
    cand   = !dup_r[scan_r] && !done_r[scan_r];
    better = !best_v_r || (cnt_r[scan_r] > best_cnt_r) ||
             ((cnt_r[scan_r] == best_cnt_r) && (scan_rgb < best_rgb_r));
    want   = (WANT_W'(n_r) < WANT_W'(cfg_cw_r)) ? WANT_W'(n_r) : WANT_W'(cfg_cw_r);
  end

  // average store: division results or all zero for empty regions
  always_ff @(posedge clk) begin
    if (cmd.avg_zero) begin
      for (int i = 0; i < NREG; i++)
        for (int c = 0; c < 3; c++) avg_r[i][c] <= '0;
    end else if (cmd.div_store) begin
      avg_r[widx][dch_r] <= (area_r == '0) ? '0 : CB'(quo);
    end
  end

  // merge pass and selection scans
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r   <= '0;
      n_r      <= '0;
      k_r      <= '0;
      dup_r    <= '0;
      done_r   <= '0;
      best_v_r <= 1'b0;
    end else begin
      if (cmd.cnt_clear) begin
        scan_r <= '0;
        n_r    <= '0;
        k_r    <= '0;
        dup_r  <= '0;
        done_r <= '0;
        for (int i = 0; i < NREG; i++) cnt_r[i] <= '0;
      end else if (cmd.cnt_step) begin
        for (int i = 0; i < NREG; i++) begin
          cnt_r[i] <= cnt_r[i] + N_W'(match[i]);
          if (match[i] && (scan_r < AV_W'(i))) dup_r[i] <= 1'b1;
        end
        if ((match & lower) == '0) n_r <= n_r + N_W'(1);
        scan_r <= (scan_r == AV_W'(NREG - 1)) ? '0 : scan_r + AV_W'(1);
      end
      if (cmd.sel_start) begin
        scan_r   <= '0;
        best_v_r <= 1'b0;
      end else if (cmd.sel_step) begin
        if (cand && better) begin
          best_v_r   <= 1'b1;
          best_idx_r <= scan_r;
          best_cnt_r <= cnt_r[scan_r];
          best_rgb_r <= scan_rgb;
        end
        scan_r <= (scan_r == AV_W'(NREG - 1)) ? '0 : scan_r + AV_W'(1);
      end
      if (cmd.emit_load) begin
        done_r[best_idx_r] <= 1'b1;
        k_r                <= k_r + N_W'(1);
      end
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      avg_red      <= FIELD_W'(best_rgb_r[3*CB-1:2*CB]);
      avg_green    <= FIELD_W'(best_rgb_r[2*CB-1:CB]);
      avg_blue     <= FIELD_W'(best_rgb_r[CB-1:0]);
      region_count <= COUNT_W'(best_cnt_r);
      final_flag   <= sts.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;

  // status to the controller
  always_comb begin
    sts.fire      = fire;
    sts.row_end   = row_end;
    sts.frame_end = col_end && row_last;
    sts.geo_busy  = geo_cnt_r != 2'd0;
    sts.div_done  = div_done;
    sts.div_last  = (dx_r == RX_W'(GRID - 1)) && (dch_r == 2'd2);
    sts.rh_zero   = rh_r == '0;
    sts.cnt_last  = scan_r == AV_W'(NREG - 1);
    sts.sel_last  = scan_r == AV_W'(NREG - 1);
    sts.want_zero = want == '0;
    sts.emit_last = (WANT_W'(k_r) + WANT_W'(1)) == want;
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule

@@ rtl/gadc_ctrl.sv @@
// ----------------------------------------------------------------------------
// gadc_ctrl
// Controller: pixel intake, per region row division, frame end ranking.
// ----------------------------------------------------------------------------
module gadc_ctrl
  import gadc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    pend_nxt  = pend_r;
    case (state_r)
      ST_RUN: begin
        cmd.accept = !sts.geo_busy;
        if (sts.fire) begin
          if (sts.row_end) begin
            state_nxt = ST_DIV;
            pend_nxt  = sts.frame_end;
          end else if (sts.frame_end) begin
            state_nxt = ST_FRAME;
          end
        end
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          if (sts.div_last) begin
            cmd.sums_clear = 1'b1;
            state_nxt      = pend_r ? ST_FRAME : ST_RUN;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_FRAME: begin
        cmd.sums_clear = 1'b1;
        cmd.avg_zero   = sts.rh_zero;
        cmd.cnt_clear  = 1'b1;
        pend_nxt       = 1'b0;
        state_nxt      = ST_CNT;
      end
      ST_CNT: begin
        cmd.cnt_step = 1'b1;
        if (sts.cnt_last) state_nxt = ST_CHK;
      end
      ST_CHK: begin
        state_nxt = sts.want_zero ? ST_RUN : ST_SELI;
      end
      ST_SELI: begin
        cmd.sel_start = 1'b1;
        state_nxt     = ST_SEL;
      end
      ST_SEL: begin
        cmd.sel_step = 1'b1;
        if (sts.sel_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = sts.emit_last ? ST_RUN : ST_SELI;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

endmodule

@@ dv/grid_average_dominant_colors_test.sv @@
// ----------------------------------------------------------------------------
// grid_average_dominant_colors_test
// Self-checking bench: streams small RGB frames through the block and checks
// every reported region color against an in-bench prediction of the averages,
// their merge counts and the count/color ranking.
// ----------------------------------------------------------------------------
module grid_average_dominant_colors_test
  import gadc_pkg::*;
();

  localparam int GRID_N    = 5;
  localparam int MAX_SIDE  = 4096;
  localparam int SETTLE    = 3000;
  localparam int LIMIT     = 2000000;

  typedef struct {
    logic [15:0] r, g, b;
  } pixel_t;

  typedef struct {
    logic [15:0] r, g, b;
    logic [4:0]  count;
    logic        last;
  } color_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [1:0]           cfg_addr   = REG_WIDTH;
  logic [CFG_DIM_W-1:0] cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [47:0]          in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [55:0]          out_tdata;
  logic                 out_tlast;

  grid_average_dominant_colors u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #6 clk = ~clk;

  // stimulus and expectations
  pixel_t pixel_q[$];
  color_t color_q[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_req = 0;
  int     hold_left = 0;
  int     cycles = 0;
  bit     beat_taken = 0;

  // predictor state
  int unsigned       pw = 640, ph = 480, pwant = 5;
  int unsigned       col_pos = 0, row_pos = 0;
  longint unsigned   rsum[GRID_N][3];
  int unsigned       ravg[GRID_N*GRID_N][3];

  function automatic int unsigned clamp_side(int unsigned v);
    if (v < 1) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  function automatic bit ranks_ahead(int unsigned na, int unsigned a[3],
                                     int unsigned nb, int unsigned b[3]);
    if (na != nb) return na > nb;
    for (int c = 0; c < 3; c++)
      if (a[c] != b[c]) return a[c] < b[c];
    return 0;
  endfunction

  // rank the frame's merged averages and queue the reported colors
  function automatic void rank_frame(int unsigned rh);
    int unsigned pal[GRID_N*GRID_N][3];
    int unsigned cnt[GRID_N*GRID_N];
    int unsigned tc[3];
    int unsigned tn, n, j, want;
    color_t e;
    n = 0;
    if (rh == 0)
      foreach (ravg[i, c]) ravg[i][c] = 0;
    for (int i = 0; i < GRID_N*GRID_N; i++) begin
      for (j = 0; j < n; j++)
        if (pal[j][0] == ravg[i][0] && pal[j][1] == ravg[i][1] &&
            pal[j][2] == ravg[i][2]) break;
      if (j == n) begin
        pal[n] = ravg[i];
        cnt[n] = 0;
        n++;
      end
      cnt[j]++;
    end
    for (int i = 1; i < n; i++) begin
      tc = pal[i];
      tn = cnt[i];
      j = i;
      while (j > 0 && ranks_ahead(tn, tc, cnt[j-1], pal[j-1])) begin
        pal[j] = pal[j-1];
        cnt[j] = cnt[j-1];
        j--;
      end
      pal[j] = tc;
      cnt[j] = tn;
    end
    want = (pwant < n) ? pwant : n;
    for (int k = 0; k < want; k++) begin
      e.r = 16'(pal[k][0]);
      e.g = 16'(pal[k][1]);
      e.b = 16'(pal[k][2]);
      e.count = 5'(cnt[k]);
      e.last = (k + 1 == want);
      color_q = {color_q, e};
    end
  endfunction

  // advance the raster position by one pixel
  function automatic void predict_pixel(pixel_t p);
    int unsigned w, h, rw, rh, rx, ry, area;
    int unsigned v[3];
    w = clamp_side(pw);
    h = clamp_side(ph);
    rw = w / GRID_N;
    rh = h / GRID_N;
    v[0] = 32'(p.r); v[1] = 32'(p.g); v[2] = 32'(p.b);
    if (col_pos < rw*GRID_N && row_pos < rh*GRID_N) begin
      rx = col_pos / rw;
      for (int c = 0; c < 3; c++) rsum[rx][c] += 64'(v[c]);
    end
    if (col_pos >= w - 1) begin
      if (rh != 0 && row_pos < rh*GRID_N && (row_pos + 1) % rh == 0) begin
        ry = row_pos / rh;
        area = rw * rh;
        for (int x = 0; x < GRID_N; x++)
          for (int c = 0; c < 3; c++)
            ravg[ry*GRID_N + x][c] = area ? 32'(rsum[x][c] / area) : 0;
        foreach (rsum[i, c]) rsum[i][c] = 0;
      end
      col_pos = 0;
      if (row_pos >= h - 1) begin
        rank_frame(rh);
        row_pos = 0;
        foreach (rsum[i, c]) rsum[i][c] = 0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // input beat accepted: predict and retire it
  always @(posedge clk) begin
    beat_taken <= 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      predict_pixel(pixel_q.pop_front());
      beat_taken <= 1'b1;
    end
  end

  // pixel driver
  always @(negedge clk) begin
    if (!in_tvalid || beat_taken) begin
      if (rst_n && pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {pixel_q[0].b, pixel_q[0].g, pixel_q[0].r};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_req > 0 && hold_left == 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    color_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (color_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, actual %h last %b", $time, out_tdata, out_tlast);
      end else begin
        e = color_q.pop_front();
        if (out_tdata[15:0] !== e.r || out_tdata[31:16] !== e.g ||
            out_tdata[47:32] !== e.b || out_tdata[52:48] !== e.count ||
            out_tlast !== e.last) begin
          errors++;
          $display("%0t: mismatch, expected rgb %h %h %h count %0d last %b, actual %h last %b",
                   $time, e.r, e.g, e.b, e.count, e.last, out_tdata, out_tlast);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DIM_W'(val);
    case (idx)
      REG_WIDTH:  pw = val & 32'h1fff;
      REG_HEIGHT: ph = val & 32'h1fff;
      REG_COLORS: pwant = val & 32'h1f;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pixel_q.size() > 0 || color_q.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // pixels of one frame: mostly region-constant palette colors so averages merge
  task automatic queue_pixels(int unsigned w, int unsigned h);
    pixel_t pal[4];
    pixel_t p;
    pixel_t tile[GRID_N*GRID_N];
    int unsigned rx, ry;
    bit noisy;
    noisy = ($urandom_range(3) == 0);
    foreach (pal[i]) begin
      pal[i].r = 16'($urandom); pal[i].g = 16'($urandom); pal[i].b = 16'($urandom);
    end
    foreach (tile[i]) tile[i] = pal[$urandom_range(3)];
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        rx = x / (w / GRID_N); ry = y / (h / GRID_N);
        if (rx >= GRID_N) rx = GRID_N - 1;
        if (ry >= GRID_N) ry = GRID_N - 1;
        p = tile[ry*GRID_N + rx];
        if (noisy || $urandom_range(9) == 0) begin
          p.r = 16'($urandom); p.g = 16'($urandom); p.b = 16'($urandom);
        end
        pixel_q = {pixel_q, p};
      end
  endtask

  // one frame with its own geometry and color count
  task automatic queue_frame(int unsigned w, int unsigned h, int unsigned want);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_COLORS, want);
    queue_pixels(w, h);
  endtask

  initial begin
    pixel_t p;
    int unsigned dv[8];
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // largest clamped size in the size registers, then the directed 5x5 frame
    write_reg(REG_WIDTH, MAX_SIDE);
    write_reg(REG_HEIGHT, MAX_SIDE);
    write_reg(REG_WIDTH, 5);
    write_reg(REG_HEIGHT, 5);
    write_reg(REG_COLORS, 25);
    dv = '{16'h0000, 16'hffff, 16'haaaa, 16'h5555, 16'h0001, 16'h8000, 16'h0000, 16'hffff};
    for (int i = 0; i < 25; i++) begin
      // repeated colors and ties in count, broken by red, green, blue
      p.r = 16'(dv[i % 8]); p.g = 16'(dv[(i / 8) % 8]); p.b = 16'(dv[(i * 3) % 8]);
      if (i >= 20) p = '{16'h1234, 16'h0000, 16'hffff};
      pixel_q = {pixel_q, p};
    end

    // idle phases: none, sender, receiver, both
    for (int ph_i = 0; ph_i < 4; ph_i++) begin
      wait_idle();
      send_idle_pct = (ph_i == 1 || ph_i == 3) ? ((ph_i == 1) ? 76 : 23) : 0;
      recv_idle_pct = (ph_i == 2 || ph_i == 3) ? ((ph_i == 2) ? 76 : 23) : 0;
      if (ph_i == 0) begin
        // two frames back to back while results are held off, so the input backs up
        queue_frame(6, 5, 25);
        queue_pixels(6, 5);
        hold_req = 8000;
      end
      queue_frame($urandom_range(5, 11), $urandom_range(5, 9),
                  (ph_i == 1) ? 0 : $urandom_range(1, 25));
    end
    queue_frame(5, 5, 1);

    wait_idle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gadc_pkg.sv
rtl/gadc_div.sv
rtl/gadc_dp.sv
rtl/gadc_ctrl.sv
rtl/grid_average_dominant_colors.sv
dv/grid_average_dominant_colors_test.sv
